FILE: sv/tremolo_wavetable_lfo_unit_defines.svh
// Assertion macros used by the checker file of the tremolo LFO unit.
`ifndef TREMOLO_WAVETABLE_LFO_UNIT_DEFINES_SVH
`define TREMOLO_WAVETABLE_LFO_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define TREM_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tremolo check failed");

// A condition that, when seen at one edge, requires another at the next edge.
`define TREM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tremolo check failed");

`endif

FILE: sv/trem_pkg.sv
// Shared types, constants and waveform tables of the tremolo LFO unit.
package trem_pkg;

	localparam int POINTS_PER_CYCLE = 50;
	localparam int WAVE_COUNT       = 4;
	localparam int POINT_W          = $clog2(POINTS_PER_CYCLE);
	localparam int WAVE_W           = 2;
	localparam int READING_W        = 12;
	localparam int DEPTH_W          = 11;
	localparam int TICK_W           = 3;
	localparam int ENTRY_W          = 17;
	localparam int LEVEL_W          = 10;
	localparam int DAC_W            = 16;
	localparam int QUEUE_DEPTH      = 2;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

	localparam logic [DEPTH_W-1:0] DEPTH_FULL     = 11'd1024;
	localparam logic [TICK_W-1:0]  INTERVAL_RESET = 3'd6;
	localparam logic [8:0]         PERIOD_BASE    = 9'd333;
	localparam logic [7:0]         RATE_SPAN      = 8'd233;
	localparam int                 PERIOD_STEP    = 50;
	localparam int                 INTERVAL_MIN   = 2;
	localparam int                 INTERVAL_MAX   = 6;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 10'd1023;
	localparam logic [3:0]         DAC_CMD        = 4'h3;

	localparam logic [0:0] ACT_TICK    = 1'b0;
	localparam logic [0:0] ACT_CONTROL = 1'b1;

	typedef struct packed {
		logic [WAVE_W-1:0]  wave;
		logic [POINT_W-1:0] point;
		logic [DEPTH_W-1:0] depth;
	} trem_job_t;

	localparam logic [ENTRY_W-1:0] WAVE_ROM [WAVE_COUNT][POINTS_PER_CYCLE] = '{
		'{17'd32768, 17'd36875, 17'd40917, 17'd44831, 17'd48554, 17'd52028, 17'd55199,
		  17'd58016, 17'd60435, 17'd62417, 17'd63932, 17'd64955, 17'd65471, 17'd65471,
		  17'd64955, 17'd63932, 17'd62417, 17'd60435, 17'd58016, 17'd55199, 17'd52028,
		  17'd48554, 17'd44831, 17'd40917, 17'd36875, 17'd32768, 17'd28661, 17'd24619,
		  17'd20705, 17'd16982, 17'd13508, 17'd10337, 17'd7520,  17'd5101,  17'd3119,
		  17'd1604,  17'd580,   17'd65,    17'd65,    17'd580,   17'd1604,  17'd3119,
		  17'd5101,  17'd7520,  17'd10337, 17'd13508, 17'd16982, 17'd20705, 17'd24619,
		  17'd28661},
		'{17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
		  17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
		  17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
		  17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd0,     17'd0,     17'd0,
		  17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0,
		  17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0,
		  17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0,
		  17'd0},
		'{17'd0,     17'd2621,  17'd5243,  17'd7864,  17'd10486, 17'd13107, 17'd15729,
		  17'd18350, 17'd20972, 17'd23593, 17'd26214, 17'd28836, 17'd31457, 17'd34079,
		  17'd36700, 17'd39322, 17'd41943, 17'd44564, 17'd47186, 17'd49807, 17'd52429,
		  17'd55050, 17'd57672, 17'd60293, 17'd62915, 17'd65536, 17'd62915, 17'd60293,
		  17'd57672, 17'd55050, 17'd52429, 17'd49807, 17'd47186, 17'd44564, 17'd41943,
		  17'd39322, 17'd36700, 17'd34079, 17'd31457, 17'd28836, 17'd26214, 17'd23593,
		  17'd20972, 17'd18350, 17'd15729, 17'd13107, 17'd10486, 17'd7864,  17'd5243,
		  17'd2621},
		'{17'd0,     17'd1337,  17'd2675,  17'd4012,  17'd5350,  17'd6687,  17'd8025,
		  17'd9362,  17'd10700, 17'd12037, 17'd13375, 17'd14712, 17'd16050, 17'd17387,
		  17'd18724, 17'd20062, 17'd21399, 17'd22737, 17'd24075, 17'd25412, 17'd26749,
		  17'd28087, 17'd29424, 17'd30762, 17'd32100, 17'd33436, 17'd34774, 17'd36112,
		  17'd37449, 17'd38787, 17'd40124, 17'd41461, 17'd42799, 17'd44137, 17'd45474,
		  17'd46812, 17'd48149, 17'd49486, 17'd50824, 17'd52161, 17'd53499, 17'd54836,
		  17'd56174, 17'd57511, 17'd58849, 17'd60186, 17'd61524, 17'd62861, 17'd64198,
		  17'd65536}
	};

endpackage

FILE: sv/trem_front.sv
// Front end: accepts items, keeps the tick and control state, issues sample jobs.
module trem_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [23:0]                         s_tdata,  // rate_reading, depth_reading
	input  logic                                s_tuser,  // action
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [trem_pkg::WAVE_W-1:0]         cfg_data,  // wave_select
	output logic                                push_valid,
	input  logic                                push_ready,
	output trem_pkg::trem_job_t                 push_job
);

	logic [trem_pkg::WAVE_W-1:0]    wave_select_q;
	logic [trem_pkg::POINT_W-1:0]   point_index_q;
	logic [trem_pkg::TICK_W-1:0]    tick_count_q;
	logic [trem_pkg::TICK_W-1:0]    interval_q;
	logic [trem_pkg::DEPTH_W-1:0]   depth_level_q;

	logic                           accept;
	logic                           is_control;
	logic [trem_pkg::READING_W-1:0] rate_r;
	logic [trem_pkg::READING_W-1:0] depth_r;
	logic [19:0]                    rate_prod;
	logic [20:0]                    rate_ceil_sum;
	logic [7:0]                     rate_ceil;
	logic [8:0]                     period;
	logic [trem_pkg::TICK_W-1:0]    interval_new;
	logic [12:0]                    depth_sum;
	logic [trem_pkg::DEPTH_W-1:0]   depth_new;
	logic [trem_pkg::TICK_W-1:0]    tick_next;
	logic                           fire;
	logic [trem_pkg::POINT_W-1:0]   point_next;

	assign cfg_ready  = 1'b1;
	assign s_tready   = push_ready;
	assign accept     = s_tvalid && s_tready;
	assign is_control = (s_tuser == trem_pkg::ACT_CONTROL);
	assign rate_r     = s_tdata[11:0];
	assign depth_r    = s_tdata[23:12];

	// period = 333 - ceil(233 * r / 4096), interval = period / 50 by threshold compare.
	always_comb begin
		rate_prod     = trem_pkg::RATE_SPAN * rate_r;
		rate_ceil_sum = {1'b0, rate_prod} + 21'd4095;
		rate_ceil     = rate_ceil_sum[19:12];
		period        = trem_pkg::PERIOD_BASE - {1'b0, rate_ceil};
		interval_new  = trem_pkg::TICK_W'(trem_pkg::INTERVAL_MIN);
		for (int k = trem_pkg::INTERVAL_MIN + 1; k <= trem_pkg::INTERVAL_MAX; k++) begin
			if (period >= 9'(k * trem_pkg::PERIOD_STEP)) begin
				interval_new = trem_pkg::TICK_W'(k);
			end
		end
		depth_sum = {1'b0, depth_r} + 13'd3;
		depth_new = trem_pkg::DEPTH_FULL - depth_sum[12:2];
	end

	assign tick_next  = tick_count_q + 3'd1;
	assign fire       = (tick_next >= interval_q);
	assign point_next = (point_index_q == trem_pkg::POINT_W'(trem_pkg::POINTS_PER_CYCLE - 1))
		? '0 : point_index_q + trem_pkg::POINT_W'(1);

	assign push_valid     = accept && !is_control && fire;
	assign push_job.wave  = wave_select_q;
	assign push_job.point = point_index_q;
	assign push_job.depth = depth_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_select_q <= '0;
			point_index_q <= '0;
			tick_count_q  <= '0;
			interval_q    <= trem_pkg::INTERVAL_RESET;
			depth_level_q <= trem_pkg::DEPTH_FULL;
		end else begin
			if (cfg_valid && cfg_ready) begin
				wave_select_q <= cfg_data;
			end
			if (accept) begin
				if (is_control) begin
					interval_q    <= interval_new;
					depth_level_q <= depth_new;
					tick_count_q  <= '0;
				end else if (fire) begin
					tick_count_q  <= '0;
					point_index_q <= point_next;
				end else begin
					tick_count_q  <= tick_next;
				end
			end
		end
	end

endmodule

FILE: sv/trem_queue.sv
// Short job queue between the front end and the sample back end.
module trem_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  trem_pkg::trem_job_t push_job,
	output logic                pop_valid,
	input  logic                pop_ready,
	output trem_pkg::trem_job_t pop_job
);

	trem_pkg::trem_job_t           slots_q [trem_pkg::QUEUE_DEPTH];
	logic [trem_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [trem_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [trem_pkg::QCNT_W-1:0]   count_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = (count_q != trem_pkg::QCNT_W'(trem_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [trem_pkg::QPTR_W-1:0] ptr_inc(
		input logic [trem_pkg::QPTR_W-1:0] p
	);
		return (p == trem_pkg::QPTR_W'(trem_pkg::QUEUE_DEPTH - 1))
			? '0 : p + trem_pkg::QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + trem_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - trem_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

FILE: sv/trem_back.sv
// Back end: waveform lookup, depth scaling and the registered output item.
module trem_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  trem_pkg::trem_job_t pop_job,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata  // level, dac_word
);

	logic                                valid_s1;
	logic [trem_pkg::ENTRY_W-1:0]        entry_s1;
	logic [trem_pkg::DEPTH_W-1:0]        depth_s1;
	logic                                valid_s2;
	logic [trem_pkg::LEVEL_W-1:0]        level_s2;

	logic                                out_free;
	logic                                s1_free;
	logic [trem_pkg::DEPTH_W-1:0]        scale;
	logic [27:0]                         product;
	logic [11:0]                         sum;
	logic [trem_pkg::LEVEL_W-1:0]        level_sat;

	assign out_free  = !valid_s2 || m_tready;
	assign s1_free   = !valid_s1 || out_free;
	assign pop_ready = s1_free;

	// level = ((1024 - depth) * entry >> 16) + depth, clipped to the 10-bit range.
	always_comb begin
		scale     = trem_pkg::DEPTH_FULL - depth_s1;
		product   = scale * entry_s1;
		sum       = product[27:16] + {1'b0, depth_s1};
		level_sat = (sum > {2'b00, trem_pkg::LEVEL_MAX}) ? trem_pkg::LEVEL_MAX : sum[9:0];
	end

	always_ff @(posedge clk) begin
		if (pop_valid && s1_free) begin
			entry_s1 <= trem_pkg::WAVE_ROM[pop_job.wave][pop_job.point];
			depth_s1 <= pop_job.depth;
		end
		if (valid_s1 && out_free) begin
			level_s2 <= level_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= pop_valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b000000, trem_pkg::DAC_CMD, level_s2, 2'b00, level_s2};

endmodule

FILE: sv/tremolo_wavetable_lfo_unit.sv
// Top level of the tremolo wavetable LFO unit.
// The unit takes one item per clock cycle, tick or control. The sample job of a tick item
// is registered in turn in the job queue, the waveform table lookup stage and the depth
// multiply stage of the back end, whose register drives the output. A front end keeps
// the millisecond tick count, the interval and the depth level, and for every tick that
// reaches the interval it queues one sample job carrying the waveform, the table point
// and the depth. A two-entry queue parts the front end from the back end, so the input
// keeps flowing while a finished result waits; the input stalls only when that queue is
// full and the output is held. Control items update the interval (period/50 ms, 2 to 6)
// and the depth level and restart the tick count; they produce no result. The waveform
// register is written through its own port and takes effect for the jobs queued after
// the write. There is no clearing pass after reset.
module tremolo_wavetable_lfo_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [23:0]                 s_tdata,  // [11:0] rate_reading, [23:12] depth_reading
	input  logic                        s_tuser,  // [0] action
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,  // [9:0] level, [25:10] dac_word
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [trem_pkg::WAVE_W-1:0] cfg_data   // wave_select
);

	// Job handshake from the front end into the queue.
	logic                push_valid;
	logic                push_ready;
	trem_pkg::trem_job_t push_job;

	// Job handshake from the queue into the back end.
	logic                pop_valid;
	logic                pop_ready;
	trem_pkg::trem_job_t pop_job;

	trem_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	trem_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// Sample generation; its output register is what the master side sees.
	trem_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

FILE: sv/trem_checker.sv
// Port-level checks of the tremolo LFO unit and their binding to the top level.
`include "tremolo_wavetable_lfo_unit_defines.svh"

module trem_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        cfg_ready
);

	// Expected upper bits of an output item: padding, command nibble, shifted level.
	logic [21:0] frame_hi;

	assign frame_hi = {6'b000000, trem_pkg::DAC_CMD, m_tdata[9:0], 2'b00};

	// The DAC frame is always the command nibble over the level shifted left by two.
	`TREM_ASSERT_ALWAYS(a_dac_frame, !m_tvalid || (m_tdata[31:10] == frame_hi))

	// A held output item stays valid and unchanged.
	`TREM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// The input stalls only when the queue is full, which needs a result waiting.
	`TREM_ASSERT_ALWAYS(a_stall_cause, s_tready || m_tvalid)

	// Register writes are never refused.
	`TREM_ASSERT_ALWAYS(a_cfg_ready, cfg_ready)

endmodule

bind tremolo_wavetable_lfo_unit trem_checker u_trem_checker (.*);

FILE: bench/testbench.sv
// Self-checking testbench for the tremolo wavetable LFO unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import trem_pkg::*;

	// Waveform codes of the wave select register.
	localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd1;
	localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd2;
	localparam logic [WAVE_W-1:0] WAVE_SAW      = 2'd3;

	// The back end has two stages, so a few extra cycles cover anything in flight.
	localparam int SETTLE_CYCLES = 6;
	// The long output stall that fills the job queue and backs up the input.
	localparam int HOLD_CYCLES   = 60;
	localparam int MAX_REPORTS   = 10;
	// Far beyond the slowest correct run.
	localparam longint TIMEOUT_NS = 2_000_000;

	// One expected sample, kept in the order the block must deliver them.
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [DAC_W-1:0]   dac;
	} sample_t;

	// One row of the directed table. Where known is set, the level is typed in by
	// hand and replaces the computed one.
	typedef struct packed {
		logic [0:0]           act;
		logic [READING_W-1:0] rate;
		logic [READING_W-1:0] depth;
		logic                 known;
		logic [LEVEL_W-1:0]   level;
	} stim_row_t;

	// The directed part runs under the square wave, written right after reset.
	// Readings on ticks are junk on purpose, since the block must ignore them.
	localparam int DIRECTED_ROWS = 24;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// Five ticks below the reset interval of six produce nothing.
		'{ACT_TICK,    12'hFFF, 12'hFFF, 1'b0, 10'd0},
		'{ACT_TICK,    12'h000, 12'h000, 1'b0, 10'd0},
		'{ACT_TICK,    12'hAAA, 12'h555, 1'b0, 10'd0},
		'{ACT_TICK,    12'h555, 12'hAAA, 1'b0, 10'd0},
		'{ACT_TICK,    12'h000, 12'hFFF, 1'b0, 10'd0},
		// Sixth tick: full depth after reset gives 1024, which saturates.
		'{ACT_TICK,    12'hFFF, 12'h000, 1'b1, 10'd1023},
		// Fastest rate and deepest setting: interval 2, depth level 0.
		'{ACT_CONTROL, 12'hFFF, 12'hFFF, 1'b0, 10'd0},
		'{ACT_TICK,    12'h123, 12'h456, 1'b0, 10'd0},
		// Square top at depth level 0 overflows to 1024 and must saturate.
		'{ACT_TICK,    12'h000, 12'h000, 1'b1, 10'd1023},
		// Slowest rate and no depth: back to interval 6 and depth level 1024.
		'{ACT_CONTROL, 12'h000, 12'h000, 1'b0, 10'd0},
		'{ACT_TICK,    12'hFFF, 12'hFFF, 1'b0, 10'd0},
		'{ACT_TICK,    12'hFFF, 12'hFFF, 1'b0, 10'd0},
		// A control item restarts the tick count: interval 3, depth level 1023.
		'{ACT_CONTROL, 12'd2900, 12'd2,  1'b0, 10'd0},
		'{ACT_TICK,    12'h000, 12'h000, 1'b0, 10'd0},
		'{ACT_TICK,    12'h000, 12'h000, 1'b0, 10'd0},
		'{ACT_TICK,    12'h000, 12'h000, 1'b1, 10'd1023},
		// Mid settings: interval 4, depth level 524.
		'{ACT_CONTROL, 12'd2048, 12'd2000, 1'b0, 10'd0},
		'{ACT_TICK,    12'hFFF, 12'h000, 1'b0, 10'd0},
		'{ACT_TICK,    12'h000, 12'hFFF, 1'b0, 10'd0},
		'{ACT_TICK,    12'hFFF, 12'hFFF, 1'b0, 10'd0},
		'{ACT_TICK,    12'h000, 12'h000, 1'b0, 10'd0},
		// Interval 5 with depth level 1.
		'{ACT_CONTROL, 12'd1024, 12'd4092, 1'b0, 10'd0},
		'{ACT_TICK,    12'h555, 12'h555, 1'b0, 10'd0},
		'{ACT_TICK,    12'hAAA, 12'hAAA, 1'b0, 10'd0}
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata   = '0;   // [11:0] rate_reading, [23:12] depth_reading
	logic                 s_tuser   = 1'b0; // [0] action
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [31:0]          m_tdata;          // [9:0] level, [25:10] dac_word
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [WAVE_W-1:0]    cfg_data  = '0;

	// Our own copy of the LFO state, advanced on every accepted item.
	logic [WAVE_W-1:0]    lfo_wave;
	logic [POINT_W-1:0]   lfo_point;
	logic [TICK_W-1:0]    lfo_ticks;
	logic [TICK_W-1:0]    lfo_interval;
	logic [DEPTH_W-1:0]   lfo_depth;

	sample_t              pending_samples [$];

	// Handshake flags between the item driver and the output side.
	bit                   hold_req;
	bit                   no_idle;

	int                   err_count;
	int                   item_count;
	int                   control_count;
	int                   sample_count;
	int                   holds_done;
	logic [WAVE_COUNT-1:0] waves_seen;

	tremolo_wavetable_lfo_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Run limit: if the block hangs, the run still ends with a verdict.
	initial begin
		#(TIMEOUT_NS);
		$display("testbench: done, errors");
		$finish;
	end

	task automatic flag_error(input string what);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Advances the LFO state by one item. Returns 1 and fills smp when the item
	// yields a sample. Control items reload interval and depth and restart the
	// tick count; ticks count up and, on reaching the interval, read the table.
	function automatic bit lfo_advance(input logic [0:0] act,
			input logic [READING_W-1:0] rate, input logic [READING_W-1:0] depth,
			output sample_t smp);
		int unsigned period;
		int unsigned entry;
		int unsigned lvl;
		smp = '0;
		if (act == ACT_CONTROL) begin
			// Period is 333 - ceil(233*r/4096) ms, the interval one fiftieth of it.
			period = int'(PERIOD_BASE)
				- (int'(RATE_SPAN) * int'(rate) + (1 << READING_W) - 1) / (1 << READING_W);
			lfo_interval = TICK_W'(period / PERIOD_STEP);
			lfo_depth    = DEPTH_FULL - DEPTH_W'((int'(depth) + 3) / 4);
			lfo_ticks    = '0;
			return 1'b0;
		end
		lfo_ticks = lfo_ticks + 1'b1;
		if (lfo_ticks < lfo_interval)
			return 1'b0;
		lfo_ticks = '0;
		entry = int'(WAVE_ROM[lfo_wave][lfo_point]);
		// The product is floored by the shift; the sum can reach 1024 and saturates.
		lvl = (((int'(DEPTH_FULL) - int'(lfo_depth)) * entry) >> 16) + int'(lfo_depth);
		if (lvl > int'(LEVEL_MAX))
			lvl = int'(LEVEL_MAX);
		lfo_point = (lfo_point == POINT_W'(POINTS_PER_CYCLE - 1)) ? '0 : lfo_point + 1'b1;
		smp.level = LEVEL_W'(lvl);
		smp.dac   = {DAC_CMD, LEVEL_W'(lvl), 2'b00};
		return 1'b1;
	endfunction

	// Offers one item, sometimes after a random gap, and waits for it to be taken.
	// The valid stays high after acceptance so that items can follow back to back.
	task automatic push_item(input logic [0:0] act, input logic [READING_W-1:0] rate,
			input logic [READING_W-1:0] depth, input logic known,
			input logic [LEVEL_W-1:0] level);
		sample_t smp;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {depth, rate};
		do @(posedge clk); while (!s_tready);
		item_count++;
		if (act == ACT_CONTROL)
			control_count++;
		if (lfo_advance(act, rate, depth, smp)) begin
			// Hand-typed rows override the computed sample.
			if (known) begin
				smp.level = level;
				smp.dac   = {DAC_CMD, level, 2'b00};
			end
			pending_samples.push_back(smp);
		end
	endtask

	// Random mix: mostly ticks, with control items carrying random readings and,
	// now and then, the extreme readings.
	task automatic random_items(input int count);
		logic [0:0]           act;
		logic [READING_W-1:0] rate;
		logic [READING_W-1:0] depth;
		int                   n;
		for (n = 0; n < count; n++) begin
			act   = ($urandom_range(0, 99) < 15) ? ACT_CONTROL : ACT_TICK;
			rate  = READING_W'($urandom);
			depth = READING_W'($urandom);
			if (act == ACT_CONTROL && $urandom_range(0, 3) == 0) begin
				rate  = $urandom_range(0, 1) ? '1 : '0;
				depth = $urandom_range(0, 1) ? '1 : '0;
			end
			push_item(act, rate, depth, 1'b0, '0);
		end
	endtask

	// Stops offering items and waits until every expected sample has come out.
	task automatic drain_samples();
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_wave(input logic [WAVE_W-1:0] wave);
		cfg_valid <= 1'b1;
		cfg_data  <= wave;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		lfo_wave = wave;
		waves_seen[wave] = 1'b1;
	endtask

	// The wave register is only changed with the block idle: drained, then a few
	// cycles more so that nothing is left in the pipeline.
	task automatic change_wave(input logic [WAVE_W-1:0] wave);
		drain_samples();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_wave(wave);
	endtask

	// Output side: ready most of the time, with random stall bursts, and one long
	// hold when the item driver asks for it.
	initial begin : sink_side
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
				hold_req = 1'b0;
				holds_done++;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 11);
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Every sample taken from the block is compared, field by field, with the
	// oldest expected one.
	always @(posedge clk) begin : sample_check
		sample_t want;
		if (arst_n && m_tvalid && m_tready) begin
			sample_count++;
			if (pending_samples.size() == 0) begin
				flag_error($sformatf("sample with none expected: level %0d dac_word %h",
					m_tdata[9:0], m_tdata[25:10]));
			end else begin
				want = pending_samples.pop_front();
				if (m_tdata[9:0] !== want.level)
					flag_error($sformatf("level: expected %0d, got %0d",
						want.level, m_tdata[9:0]));
				if (m_tdata[25:10] !== want.dac)
					flag_error($sformatf("dac_word: expected %h, got %h",
						want.dac, m_tdata[25:10]));
			end
		end
	end

	initial begin : stimulus
		stim_row_t row;
		int        n;

		lfo_wave     = WAVE_SINE;
		lfo_point    = '0;
		lfo_ticks    = '0;
		lfo_interval = INTERVAL_RESET;
		lfo_depth    = DEPTH_FULL;
		waves_seen   = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the square wave, whose top half exposes the overflow.
		write_wave(WAVE_SQUARE);
		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			push_item(row.act, row.rate, row.depth, row.known, row.level);
		end

		// Random phases, one per waveform setting.
		change_wave(WAVE_SINE);
		random_items(200);

		change_wave(WAVE_SAW);
		random_items(150);
		// Long output hold: the fastest interval makes samples pile up, the job
		// queue fills and the input must stall while items keep being offered.
		hold_req = 1'b1;
		push_item(ACT_CONTROL, '1, READING_W'($urandom), 1'b0, '0);
		for (n = 0; n < 40; n++)
			push_item(ACT_TICK, READING_W'($urandom), READING_W'($urandom), 1'b0, '0);
		random_items(100);

		// A stretch with no idling on either side.
		change_wave(WAVE_TRIANGLE);
		no_idle = 1'b1;
		random_items(150);
		no_idle = 1'b0;

		change_wave(WAVE_SQUARE);
		random_items(150);

		// Last phase runs at full rate.
		change_wave(WAVE_W'($urandom));
		no_idle = 1'b1;
		random_items(150);

		drain_samples();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Coverage: %0d items (%0d control), %0d samples checked.",
			item_count, control_count, sample_count);
		$display("Waveforms used %b, long output holds %0d, mismatches %0d.",
			waves_seen, holds_done, err_count);
		if (err_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
